// ===== rtl/core/lts_pkg.sv =====
// Shared types, character codes and helpers for the Lua token scanner.
`default_nettype none

package lts_pkg;

    // Record field widths and limits
    localparam int TOK_W                 = 24;
    localparam int MAX_RESULTS           = 10;
    localparam int CNT_W                 = $clog2(MAX_RESULTS + 1);
    localparam int CMD_DEPTH             = 4;
    localparam int DEF_MAX_BRACKET_LEVEL = 8;
    localparam int DEF_POS_BITS          = 24;

    // Character codes
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    typedef enum logic [2:0] {
        CLS_COMMENT = 3'd0,
        CLS_STRING  = 3'd1,
        CLS_WORD    = 3'd2,
        CLS_OPER    = 3'd3,
        CLS_ERROR   = 3'd4
    } t_tok_class;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_WORD      = 4'd1,
        M_DASH      = 4'd2,
        M_DOT1      = 4'd3,
        M_DOT2      = 4'd4,
        M_CMP       = 4'd5,
        M_COM_START = 4'd6,
        M_COM_OPEN  = 4'd7,
        M_LINE      = 4'd8,
        M_LONG_COM  = 4'd9,
        M_QUOTE     = 4'd10,
        M_STR_OPEN  = 4'd11,
        M_LONG_STR  = 4'd12
    } t_mode;

    // Input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_in;

    // Result item
    typedef struct packed {
        logic [TOK_W-1:0] tok_start;
        logic [TOK_W-1:0] tok_end;
        logic [2:0]       tok_class;
        logic             run_last;
    } t_tok_out;

    // Work handed from scanner to record expander: a run of a_count records
    // (start and end step by one after each), then an optional record B.
    typedef struct packed {
        logic [CNT_W-1:0] a_count;
        logic [TOK_W-1:0] a_start;
        logic [TOK_W-1:0] a_end;
        t_tok_class       a_class;
        logic             b_valid;
        logic [TOK_W-1:0] b_start;
        logic [TOK_W-1:0] b_end;
        t_tok_class       b_class;
    } t_cmd;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Letters, digits, underscore and all high bytes
    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER) || c[7];
    endfunction

    // Operator bytes that stand alone; the scanner decodes '-' and '[' first
    function automatic logic is_single_op(input logic [7:0] c);
        logic r;
        case (c) inside
            8'h3D, 8'h23, 8'h3A, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7B, 8'h7D,
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h25, 8'h2C, 8'h3B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lts_front.sv =====
// Scanner front end: per-byte token state machine, emits work to the queue.
`default_nettype none

module lts_front #(
    parameter int MAX_BRACKET_LEVEL = lts_pkg::DEF_MAX_BRACKET_LEVEL,
    parameter int POS_BITS          = lts_pkg::DEF_POS_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_text_valid,
    output logic                  o_text_ready,
    input  wire lts_pkg::t_text_in i_text,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output lts_pkg::t_cmd         o_cmd
);
    import lts_pkg::*;

    localparam int LVL_W = $clog2(MAX_BRACKET_LEVEL + 1);
    localparam int CLS_W = $clog2(MAX_BRACKET_LEVEL + 2);

    t_mode               r_mode,   n_mode;
    logic [LVL_W-1:0]    r_open,   n_open;
    logic [CLS_W-1:0]    r_close,  n_close;
    logic                r_quote,  n_quote;
    logic [POS_BITS-1:0] r_begin,  n_begin;
    logic [POS_BITS-1:0] r_pos,    n_pos;
    logic                r_halted, n_halted;

    logic [7:0]          c;
    logic                eot;
    logic                text_fire;
    logic [POS_BITS-1:0] pos_nxt;
    logic                open_room;
    logic                close_eq;
    logic                close_lt;
    logic [7:0]          quote_ch;

    // Phase A: the current mode reacts to the byte
    t_mode            pa_mode;
    logic [LVL_W-1:0] pa_open;
    logic [CLS_W-1:0] pa_close;
    logic             a_emit;
    logic             a_burst;
    logic             a_to_nxt;
    t_tok_class       a_class;
    logic             rescan;

    // Idle decode: the byte taken as the start of a new token
    t_mode      id_mode;
    logic       id_open_clr;
    logic       id_quote_set;
    logic       id_emit;
    t_tok_class id_class;
    logic       id_halt;

    logic [CLS_W-1:0] lvl_p1;
    logic [CNT_W-1:0] burst_n;

    assign c            = i_text.text_byte;
    assign eot          = i_text.end_of_text;
    assign o_text_ready = !i_q_full;
    assign text_fire    = i_text_valid && o_text_ready;
    assign pos_nxt      = r_pos + POS_BITS'(1);
    assign open_room    = (int'(r_open) < MAX_BRACKET_LEVEL);
    assign close_eq     = (r_close != '0) && (r_close == CLS_W'(r_open) + CLS_W'(1));
    assign close_lt     = (r_close != '0) && (r_close <= CLS_W'(r_open));
    assign quote_ch     = r_quote ? CH_SQUOTE : CH_DQUOTE;

    // Failed bracket open: '[' plus one record per '=', capped per byte
    assign lvl_p1  = CLS_W'(r_open) + CLS_W'(1);
    assign burst_n = (int'(lvl_p1) >= MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : CNT_W'(lvl_p1);

    // Phase A decode
    always_comb begin : phase_a
        pa_mode  = r_mode;
        pa_open  = r_open;
        pa_close = r_close;
        a_emit   = 1'b0;
        a_burst  = 1'b0;
        a_to_nxt = 1'b0;
        a_class  = CLS_OPER;
        rescan   = 1'b0;
        unique case (r_mode) inside
            M_IDLE: begin
                rescan = 1'b1;
            end
            M_WORD: begin
                if (!is_word(c)) begin
                    a_emit  = 1'b1;
                    a_class = CLS_WORD;
                    pa_mode = M_IDLE;
                    rescan  = 1'b1;
                end
            end
            M_DASH: begin
                if (c == CH_DASH) begin
                    pa_mode = M_COM_START;
                end else begin
                    a_emit  = 1'b1;
                    pa_mode = M_IDLE;
                    rescan  = 1'b1;
                end
            end
            M_DOT1: begin
                if (c == CH_DOT) begin
                    pa_mode = M_DOT2;
                end else begin
                    a_emit  = 1'b1;
                    pa_mode = M_IDLE;
                    rescan  = 1'b1;
                end
            end
            M_DOT2, M_CMP: begin
                a_emit  = 1'b1;
                pa_mode = M_IDLE;
                if (c == ((r_mode == M_DOT2) ? CH_DOT : CH_EQ)) begin
                    a_to_nxt = 1'b1;
                end else begin
                    rescan = 1'b1;
                end
            end
            M_COM_START, M_COM_OPEN: begin
                if (c == CH_LBRACK && r_mode == M_COM_START) begin
                    pa_open = '0;
                    pa_mode = M_COM_OPEN;
                end else if (c == CH_EQ && r_mode == M_COM_OPEN && open_room) begin
                    pa_open = r_open + LVL_W'(1);
                end else if (c == CH_LBRACK && r_mode == M_COM_OPEN) begin
                    pa_close = '0;
                    pa_mode  = M_LONG_COM;
                end else if (c == CH_NL) begin
                    a_emit   = 1'b1;
                    a_class  = CLS_COMMENT;
                    a_to_nxt = 1'b1;
                    pa_mode  = M_IDLE;
                end else begin
                    pa_mode = M_LINE;
                end
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    a_emit   = 1'b1;
                    a_class  = CLS_COMMENT;
                    a_to_nxt = 1'b1;
                    pa_mode  = M_IDLE;
                end
            end
            M_LONG_COM, M_LONG_STR: begin
                if (c == CH_RBRACK) begin
                    if (close_eq) begin
                        a_emit   = 1'b1;
                        a_class  = (r_mode == M_LONG_COM) ? CLS_COMMENT : CLS_STRING;
                        a_to_nxt = 1'b1;
                        pa_mode  = M_IDLE;
                        pa_close = '0;
                    end else begin
                        pa_close = CLS_W'(1);
                    end
                end else if (c == CH_EQ && close_lt) begin
                    pa_close = r_close + CLS_W'(1);
                end else begin
                    pa_close = '0;
                end
            end
            M_QUOTE: begin
                if (c == CH_NL || c == quote_ch) begin
                    a_emit   = 1'b1;
                    a_class  = CLS_STRING;
                    a_to_nxt = 1'b1;
                    pa_mode  = M_IDLE;
                end
            end
            M_STR_OPEN: begin
                if (c == CH_EQ && open_room) begin
                    pa_open = r_open + LVL_W'(1);
                end else if (c == CH_LBRACK) begin
                    pa_close = '0;
                    pa_mode  = M_LONG_STR;
                end else begin
                    a_burst = 1'b1;
                    pa_mode = M_IDLE;
                    rescan  = 1'b1;
                end
            end
            default: begin
                pa_mode = M_IDLE;
                rescan  = 1'b1;
            end
        endcase
    end

    // Idle decode
    always_comb begin : idle_decode
        id_mode      = M_IDLE;
        id_open_clr  = 1'b0;
        id_quote_set = 1'b0;
        id_emit      = 1'b0;
        id_class     = CLS_OPER;
        id_halt      = 1'b0;
        if (!is_space(c)) begin
            if (c == CH_DASH) begin
                id_mode = M_DASH;
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                id_quote_set = 1'b1;
                id_mode      = M_QUOTE;
            end else if (c == CH_LBRACK) begin
                id_open_clr = 1'b1;
                id_mode     = M_STR_OPEN;
            end else if (is_word(c)) begin
                id_mode = M_WORD;
            end else if (c == CH_DOT) begin
                id_mode = M_DOT1;
            end else if (c == CH_LT || c == CH_GT || c == CH_TILDE) begin
                id_mode = M_CMP;
            end else if (is_single_op(c)) begin
                id_emit = 1'b1;
            end else begin
                id_emit  = 1'b1;
                id_class = CLS_ERROR;
                id_halt  = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin : next_state
        n_mode   = r_mode;
        n_open   = r_open;
        n_close  = r_close;
        n_quote  = r_quote;
        n_begin  = r_begin;
        n_pos    = r_pos;
        n_halted = r_halted;
        if (text_fire) begin
            if (eot) begin
                n_mode   = M_IDLE;
                n_open   = '0;
                n_close  = '0;
                n_quote  = 1'b0;
                n_begin  = '0;
                n_pos    = '0;
                n_halted = 1'b0;
            end else if (!r_halted) begin
                n_pos   = pos_nxt;
                n_close = pa_close;
                if (rescan) begin
                    n_begin  = r_pos;
                    n_mode   = id_mode;
                    n_open   = id_open_clr ? '0 : pa_open;
                    n_quote  = id_quote_set ? (c == CH_SQUOTE) : r_quote;
                    n_halted = id_halt;
                end else begin
                    n_mode = pa_mode;
                    n_open = pa_open;
                end
            end
        end
    end

    // Outputs: work item for the queue
    always_comb begin : outputs
        o_cmd         = '0;
        o_cmd.a_class = CLS_OPER;
        o_cmd.b_class = CLS_OPER;
        if (eot) begin
            // Flush whatever token is still open
            if (!r_halted && r_mode != M_IDLE) begin
                o_cmd.a_start = TOK_W'(r_begin);
                o_cmd.a_end   = TOK_W'(r_pos);
                o_cmd.a_count = CNT_W'(1);
                unique case (r_mode) inside
                    M_WORD:                                         o_cmd.a_class = CLS_WORD;
                    M_DASH, M_DOT1, M_DOT2, M_CMP:                  o_cmd.a_class = CLS_OPER;
                    M_COM_START, M_COM_OPEN, M_LINE, M_LONG_COM:    o_cmd.a_class = CLS_COMMENT;
                    M_QUOTE, M_LONG_STR:                            o_cmd.a_class = CLS_STRING;
                    M_STR_OPEN: begin
                        o_cmd.a_end   = TOK_W'(r_begin + POS_BITS'(1));
                        o_cmd.a_count = burst_n;
                    end
                    default:                                        o_cmd.a_count = '0;
                endcase
            end
        end else if (!r_halted) begin
            o_cmd.a_start = TOK_W'(r_begin);
            o_cmd.a_class = a_class;
            if (a_burst) begin
                o_cmd.a_end   = TOK_W'(r_begin + POS_BITS'(1));
                o_cmd.a_count = burst_n;
            end else if (a_emit) begin
                o_cmd.a_end   = a_to_nxt ? TOK_W'(pos_nxt) : TOK_W'(r_pos);
                o_cmd.a_count = CNT_W'(1);
            end
            o_cmd.b_valid = rescan && id_emit && (int'(o_cmd.a_count) < MAX_RESULTS);
            o_cmd.b_start = TOK_W'(r_pos);
            o_cmd.b_end   = TOK_W'(pos_nxt);
            o_cmd.b_class = id_class;
        end
        o_push = text_fire && ((o_cmd.a_count != '0) || o_cmd.b_valid);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_open   <= '0;
            r_close  <= '0;
            r_quote  <= 1'b0;
            r_begin  <= '0;
            r_pos    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_open   <= n_open;
            r_close  <= n_close;
            r_quote  <= n_quote;
            r_begin  <= n_begin;
            r_pos    <= n_pos;
            r_halted <= n_halted;
        end
    end

    // Halted scanner produces no work for ordinary bytes
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && text_fire && !eot) |-> !o_push)
        else $error("work pushed while halted");

    // End of text always returns the scanner to its reset state
    a_eot_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (text_fire && eot) |=> (r_mode == M_IDLE && !r_halted && r_pos == '0))
        else $error("scanner not reset after end of text");

endmodule

`default_nettype wire

// ===== rtl/core/lts_cmd_fifo.sv =====
// Short work queue between the scanner and the record expander.
`default_nettype none

module lts_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lts_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output lts_pkg::t_cmd      o_cmd
);
    import lts_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int FIL_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [FIL_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FIL_W'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + FIL_W'(1);
            2'b01:   n_count = r_count - FIL_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty work queue");

endmodule

`default_nettype wire

// ===== rtl/core/lts_back.sv =====
// Record expander: turns queued work into records, one per cycle unless stalled.
`default_nettype none

module lts_back #(
    parameter int POS_BITS = lts_pkg::DEF_POS_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire lts_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_tok_valid,
    input  wire logic          i_tok_ready,
    output lts_pkg::t_tok_out  o_tok
);
    import lts_pkg::*;

    // Offsets wrap at the narrower of the position counter and the record field
    localparam int MASK_BITS = (POS_BITS < TOK_W) ? POS_BITS : TOK_W;
    localparam logic [TOK_W-1:0] WRAP_MASK = TOK_W'((64'd1 << MASK_BITS) - 64'd1);

    logic             r_act;
    logic [CNT_W-1:0] r_rem;
    logic [TOK_W-1:0] r_a_start;
    logic [TOK_W-1:0] r_a_end;
    t_tok_class       r_a_class;
    logic             r_b_valid;
    logic [TOK_W-1:0] r_b_start;
    logic [TOK_W-1:0] r_b_end;
    t_tok_class       r_b_class;
    logic             r_out_valid;
    t_tok_out         r_out;

    logic     slot_free;
    logic     emit;
    logic     emit_a;
    logic     rec_last;
    t_tok_out rec;

    assign slot_free   = !r_out_valid || i_tok_ready;
    assign emit        = slot_free && r_act;
    assign emit_a      = (r_rem != '0);
    assign rec_last    = emit_a ? ((r_rem == CNT_W'(1)) && !r_b_valid) : 1'b1;
    assign o_q_pop     = i_q_valid && (!r_act || (emit && rec_last));
    assign o_tok_valid = r_out_valid;
    assign o_tok       = r_out;

    // Pick the next record of the active work item
    always_comb begin
        rec.tok_start = emit_a ? r_a_start : r_b_start;
        rec.tok_end   = emit_a ? r_a_end : r_b_end;
        rec.tok_class = emit_a ? r_a_class : r_b_class;
        rec.run_last  = rec_last;
    end

    // Active work item: load, step through the run, retire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_rem <= '0;
        end else if (o_q_pop) begin
            r_act <= 1'b1;
            r_rem <= i_q_cmd.a_count;
        end else if (emit && rec_last) begin
            r_act <= 1'b0;
        end else if (emit && emit_a) begin
            r_rem <= r_rem - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_start <= i_q_cmd.a_start;
            r_a_end   <= i_q_cmd.a_end;
            r_a_class <= i_q_cmd.a_class;
            r_b_valid <= i_q_cmd.b_valid;
            r_b_start <= i_q_cmd.b_start;
            r_b_end   <= i_q_cmd.b_end;
            r_b_class <= i_q_cmd.b_class;
        end else if (emit && emit_a) begin
            r_a_start <= (r_a_start + TOK_W'(1)) & WRAP_MASK;
            r_a_end   <= (r_a_end + TOK_W'(1)) & WRAP_MASK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_tok_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= rec;
        end
    end

    // A record that is not the last of its byte leaves more work behind
    a_more_after_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_tok_ready && !r_out.run_last) |-> r_act)
        else $error("non-final record without pending work");

    // An active item with its run used up still owes record B
    a_b_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && r_rem == '0) |-> r_b_valid)
        else $error("active work item with nothing left to emit");

endmodule

`default_nettype wire

// ===== rtl/core/lua_token_scanner_core.sv =====
// Top level of the Lua token scanner: scanner, work queue and record expander.
`default_nettype none

// Takes source text one byte per cycle and delivers token records (start,
// end one past the last byte, class). The scanner accepts a byte every cycle
// while its four-entry work queue has room; a byte that completes tokens
// queues one work item, and the expander turns it into records at one record
// per cycle on the output register while the receiver is ready. Most bytes
// give zero or one record; a failed long-bracket open of level k gives k+1
// operator records plus possibly one more, so the output port sets the pace
// during such bursts. Records pass from the work queue through the expander.
// An unknown byte yields an error record and the block ignores text until an
// end-of-text item, which flushes any open token and resets the scanner.
module lua_token_scanner_core #(
    parameter int MAX_BRACKET_LEVEL = lts_pkg::DEF_MAX_BRACKET_LEVEL,
    parameter int POS_BITS          = lts_pkg::DEF_POS_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_text_valid,
    output logic                   o_text_ready,
    input  wire lts_pkg::t_text_in i_text,
    output logic                   o_tok_valid,
    input  wire logic              i_tok_ready,
    output lts_pkg::t_tok_out      o_tok
);
    import lts_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    lts_front #(
        .MAX_BRACKET_LEVEL (MAX_BRACKET_LEVEL),
        .POS_BITS          (POS_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_valid (i_text_valid),
        .o_text_ready (o_text_ready),
        .i_text       (i_text),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    lts_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    lts_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_tok_valid (o_tok_valid),
        .i_tok_ready (i_tok_ready),
        .o_tok       (o_tok)
    );

endmodule

`default_nettype wire

// ===== test/tb_lua_token_scanner_core.sv =====
// Self-checking testbench for the Lua token scanner core: directed and random source text.
module tb_lua_token_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lts_pkg::*;

    localparam int MAX_LVL     = DEF_MAX_BRACKET_LEVEL;
    localparam int PHASE_ITEMS = 82;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic     i_clk        = 1'b0;
    logic     i_rst_n      = 1'b0;
    logic     i_text_valid = 1'b0;
    logic     i_tok_ready  = 1'b0;
    t_text_in i_text       = '0;
    logic     o_text_ready;
    logic     o_tok_valid;
    t_tok_out o_tok;

    lua_token_scanner_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_valid (i_text_valid),
        .o_text_ready (o_text_ready),
        .i_text       (i_text),
        .o_tok_valid  (o_tok_valid),
        .i_tok_ready  (i_tok_ready),
        .o_tok        (o_tok)
    );

    // Source items waiting to go out, and token records still owed by the block
    t_text_in text_pending[$];
    t_tok_out tok_expected[$];
    t_tok_out step_toks[$];

    int  send_idle_pct  = 12;
    int  recv_stall_pct = 68;
    logic text_taken    = 1'b0;
    int  items_queued   = 0;
    int  items_sent     = 0;
    int  eot_sent       = 0;
    int  records_seen   = 0;
    int  err_count      = 0;
    int  cycle_count    = 0;

    string op_chars   = ".<>~=#:(){}+-*/^%,;[]";
    string body_chars = "]]=a \n[";

    // Shadow copy of the scanner state
    t_mode       sc_mode;
    int unsigned sc_open;
    int unsigned sc_close;
    bit          sc_quote;
    logic [23:0] sc_begin;
    logic [23:0] sc_pos;
    bit          sc_halted;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Byte classes
    // ---------------------------------------------------------------
    function automatic bit ws_byte(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit word_byte(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == CH_UNDER || c >= 8'd128;
    endfunction

    function automatic bit lone_op_byte(logic [7:0] c);
        for (int k = 0; k < op_chars.len(); k++) begin
            if (c == op_chars[k] && c != CH_DOT && c != CH_LT && c != CH_GT &&
                c != CH_TILDE) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic void clear_scanner();
        sc_mode   = M_IDLE;
        sc_open   = 0;
        sc_close  = 0;
        sc_quote  = 1'b0;
        sc_begin  = '0;
        sc_pos    = '0;
        sc_halted = 1'b0;
    endfunction

    function automatic void add_tok(logic [23:0] s, logic [23:0] e, t_tok_class cls);
        t_tok_out t;
        if (step_toks.size() >= MAX_RESULTS) begin
            return;
        end
        t.tok_start = s;
        t.tok_end   = e;
        t.tok_class = cls;
        t.run_last  = 1'b0;
        step_toks.push_back(t);
    endfunction

    // A bracket open that broke: '[' and each '=' as single operators
    function automatic void add_bracket_ops();
        for (int i = 0; i <= int'(sc_open); i++) begin
            add_tok(sc_begin + 24'(i), sc_begin + 24'(i) + 24'd1, CLS_OPER);
        end
    endfunction

    // Tracks a closing bracket; true once it matches the opening level
    function automatic bit long_close(logic [7:0] c);
        if (c == CH_RBRACK) begin
            if (sc_close != 0 && sc_close - 1 == sc_open) begin
                return 1'b1;
            end
            sc_close = 1;
        end else if (c == CH_EQ && sc_close != 0 && sc_close - 1 < sc_open) begin
            sc_close++;
        end else begin
            sc_close = 0;
        end
        return 1'b0;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [23:0] pos, logic [23:0] nxt);
        sc_begin = pos;
        if (ws_byte(c)) begin
            return;
        end
        if (c == CH_DASH) begin
            sc_mode = M_DASH;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            sc_quote = (c == CH_SQUOTE);
            sc_mode  = M_QUOTE;
        end else if (c == CH_LBRACK) begin
            sc_open = 0;
            sc_mode = M_STR_OPEN;
        end else if (word_byte(c)) begin
            sc_mode = M_WORD;
        end else if (c == CH_DOT) begin
            sc_mode = M_DOT1;
        end else if (c == CH_LT || c == CH_GT || c == CH_TILDE) begin
            sc_mode = M_CMP;
        end else if (lone_op_byte(c)) begin
            add_tok(pos, nxt, CLS_OPER);
        end else begin
            add_tok(pos, nxt, CLS_ERROR);
            sc_halted = 1'b1;
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [23:0] pos;
        logic [23:0] nxt;
        bit          again;
        pos   = sc_pos;
        nxt   = sc_pos + 24'd1;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (sc_mode)
                M_WORD: begin
                    if (!word_byte(c)) begin
                        add_tok(sc_begin, pos, CLS_WORD);
                        sc_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_DASH: begin
                    if (c == CH_DASH) begin
                        sc_mode = M_COM_START;
                    end else begin
                        add_tok(sc_begin, pos, CLS_OPER);
                        sc_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_DOT1: begin
                    if (c == CH_DOT) begin
                        sc_mode = M_DOT2;
                    end else begin
                        add_tok(sc_begin, pos, CLS_OPER);
                        sc_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_DOT2, M_CMP: begin
                    if (c == ((sc_mode == M_DOT2) ? CH_DOT : CH_EQ)) begin
                        add_tok(sc_begin, nxt, CLS_OPER);
                    end else begin
                        add_tok(sc_begin, pos, CLS_OPER);
                        again = 1'b1;
                    end
                    sc_mode = M_IDLE;
                end
                M_COM_START, M_COM_OPEN: begin
                    if (c == CH_LBRACK && sc_mode == M_COM_START) begin
                        sc_open = 0;
                        sc_mode = M_COM_OPEN;
                    end else if (c == CH_EQ && sc_mode == M_COM_OPEN && sc_open < MAX_LVL) begin
                        sc_open++;
                    end else if (c == CH_LBRACK && sc_mode == M_COM_OPEN) begin
                        sc_close = 0;
                        sc_mode  = M_LONG_COM;
                    end else if (c == CH_NL) begin
                        add_tok(sc_begin, nxt, CLS_COMMENT);
                        sc_mode = M_IDLE;
                    end else begin
                        sc_mode = M_LINE;
                    end
                end
                M_LINE: begin
                    if (c == CH_NL) begin
                        add_tok(sc_begin, nxt, CLS_COMMENT);
                        sc_mode = M_IDLE;
                    end
                end
                M_LONG_COM, M_LONG_STR: begin
                    if (long_close(c)) begin
                        if (sc_mode == M_LONG_COM) begin
                            add_tok(sc_begin, nxt, CLS_COMMENT);
                        end else begin
                            add_tok(sc_begin, nxt, CLS_STRING);
                        end
                        sc_mode  = M_IDLE;
                        sc_close = 0;
                    end
                end
                M_QUOTE: begin
                    if (c == CH_NL || c == (sc_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                        add_tok(sc_begin, nxt, CLS_STRING);
                        sc_mode = M_IDLE;
                    end
                end
                M_STR_OPEN: begin
                    if (c == CH_EQ && sc_open < MAX_LVL) begin
                        sc_open++;
                    end else if (c == CH_LBRACK) begin
                        sc_close = 0;
                        sc_mode  = M_LONG_STR;
                    end else begin
                        add_bracket_ops();
                        sc_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                default: begin
                    start_token(c, pos, nxt);
                end
            endcase
            if (sc_halted) begin
                again = 1'b0;
            end
        end
        sc_pos = nxt;
    endfunction

    // End of text: close whatever is open, then back to reset
    function automatic void flush_text();
        if (!sc_halted) begin
            case (sc_mode)
                M_WORD:                                 add_tok(sc_begin, sc_pos, CLS_WORD);
                M_DASH, M_DOT1, M_DOT2, M_CMP:          add_tok(sc_begin, sc_pos, CLS_OPER);
                M_COM_START, M_COM_OPEN, M_LINE, M_LONG_COM:
                                                        add_tok(sc_begin, sc_pos, CLS_COMMENT);
                M_QUOTE, M_LONG_STR:                    add_tok(sc_begin, sc_pos, CLS_STRING);
                M_STR_OPEN:                             add_bracket_ops();
                default: ;
            endcase
        end
        clear_scanner();
    endfunction

    function automatic void predict_tokens(t_text_in it);
        t_tok_out last;
        step_toks.delete();
        if (it.end_of_text) begin
            flush_text();
        end else if (!sc_halted) begin
            scan_byte(it.text_byte);
        end
        if (step_toks.size() > 0) begin
            last          = step_toks.pop_back();
            last.run_last = 1'b1;
            step_toks.push_back(last);
        end
        foreach (step_toks[k]) begin
            tok_expected.push_back(step_toks[k]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch on %s at record %0d: got %0h, want %0h",
                 what, records_seen, got, want);
        err_count++;
    endtask

    task automatic check_token(t_tok_out got);
        t_tok_out want;
        records_seen++;
        if (tok_expected.size() == 0) begin
            report_mismatch("unexpected record", 32'(got.tok_start), 32'hffff_ffff);
            return;
        end
        want = tok_expected.pop_front();
        if (got.tok_start !== want.tok_start) begin
            report_mismatch("tok_start", 32'(got.tok_start), 32'(want.tok_start));
        end
        if (got.tok_end !== want.tok_end) begin
            report_mismatch("tok_end", 32'(got.tok_end), 32'(want.tok_end));
        end
        if (got.tok_class !== want.tok_class) begin
            report_mismatch("tok_class", 32'(got.tok_class), 32'(want.tok_class));
        end
        if (got.run_last !== want.run_last) begin
            report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
        end
    endtask

    // Monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_taken <= 1'b0;
        end else begin
            text_taken <= i_text_valid && o_text_ready;
            if (o_tok_valid && i_tok_ready) begin
                check_token(o_tok);
            end
            if (i_text_valid && o_text_ready) begin
                items_sent++;
                if (i_text.end_of_text) begin
                    eot_sent++;
                end
                predict_tokens(i_text);
            end
        end
    end

    // Driver: next item and receiver readiness change at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_text_valid || text_taken) begin
                if (text_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_text       <= text_pending.pop_front();
                    i_text_valid <= 1'b1;
                end else begin
                    i_text_valid <= 1'b0;
                end
            end
            i_tok_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: no progress after %0d cycles, %0d records still owed",
                     cycle_count, tok_expected.size());
            $display("tb_lua_token_scanner_core: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Source text generation
    // ---------------------------------------------------------------
    function automatic void push_byte(logic [7:0] b);
        t_text_in it;
        it.text_byte   = b;
        it.end_of_text = 1'b0;
        text_pending.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            push_byte(s[k]);
        end
    endfunction

    function automatic void push_eot();
        t_text_in it;
        it.text_byte   = 8'($urandom_range(0, 255));
        it.end_of_text = 1'b1;
        text_pending.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [7:0] pick_word_byte();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(48, 57));
            1:       return 8'($urandom_range(97, 122));
            2:       return 8'($urandom_range(65, 90));
            3:       return CH_UNDER;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // Any byte but the newline, for comment and quote bodies
    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(32, 255));
        return (b == CH_NL) ? 8'd32 : b;
    endfunction

    // Level of a long bracket: mostly shallow, sometimes past the maximum
    function automatic int pick_level();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, MAX_LVL + 1);
        end
        return $urandom_range(0, 2);
    endfunction

    function automatic void push_long(bit as_comment);
        int lvl;
        lvl = pick_level();
        if (as_comment) begin
            push_text("--");
        end
        push_byte(CH_LBRACK);
        repeat (lvl) push_byte(CH_EQ);
        push_byte(CH_LBRACK);
        repeat ($urandom_range(0, 6)) push_byte(body_chars[$urandom_range(0, body_chars.len() - 1)]);
        // Mostly a matching close, now and then one of the wrong level
        if ($urandom_range(0, 5) == 0) begin
            lvl = lvl ^ 1;
        end
        push_byte(CH_RBRACK);
        repeat (lvl) push_byte(CH_EQ);
        push_byte(CH_RBRACK);
    endfunction

    function automatic void add_fragment();
        int   kind;
        logic [7:0] q;
        kind = $urandom_range(0, 99);
        if (kind < 14) begin
            repeat ($urandom_range(1, 5)) push_byte(pick_word_byte());
        end else if (kind < 26) begin
            repeat ($urandom_range(1, 2)) begin
                push_byte(($urandom_range(0, 1) == 0) ? 8'd32 : 8'($urandom_range(9, 13)));
            end
        end else if (kind < 36) begin
            // line comment, sometimes with a bracket open that breaks
            push_text("--");
            if ($urandom_range(0, 2) == 0) begin
                push_byte(CH_LBRACK);
                repeat ($urandom_range(0, MAX_LVL + 1)) push_byte(CH_EQ);
            end
            repeat ($urandom_range(0, 4)) push_byte(pick_plain_byte());
            if ($urandom_range(0, 4) != 0) begin
                push_byte(CH_NL);
            end
        end else if (kind < 48) begin
            push_long(1'b1);
        end else if (kind < 58) begin
            push_long(1'b0);
        end else if (kind < 68) begin
            q = ($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE;
            push_byte(q);
            repeat ($urandom_range(0, 4)) push_byte(pick_plain_byte());
            case ($urandom_range(0, 3))
                0:       push_byte(CH_NL);
                1:       push_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                default: push_byte(q);
            endcase
        end else if (kind < 80) begin
            repeat ($urandom_range(1, 3)) push_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        end else if (kind < 88) begin
            // bracket open broken by some other byte
            push_byte(CH_LBRACK);
            repeat ($urandom_range(0, MAX_LVL + 1)) push_byte(CH_EQ);
            push_byte(($urandom_range(0, 1) == 0) ? pick_word_byte() : 8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
            push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) begin
                push_eot();
            end
        end else begin
            push_eot();
        end
    endfunction

    function automatic void add_random_text(int count);
        int target;
        target = items_queued + count;
        while (items_queued < target) begin
            add_fragment();
        end
    endfunction

    task automatic wait_drained();
        while (text_pending.size() != 0 || i_text_valid || tok_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        clear_scanner();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bracket open with one '=' too many (ten records from one byte),
        // dots, compare with '=', dash, quote to newline, high byte, unknown byte
        // halting the scanner, ignored byte, end of text.
        push_text("[=========<...~=-'a\n");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte("z");
        push_eot();

        // Slow receiver, then slow sender, then full rate
        add_random_text(PHASE_ITEMS);
        wait_drained();
        send_idle_pct  = 68;
        recv_stall_pct = 12;
        add_random_text(PHASE_ITEMS);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random_text(PHASE_ITEMS);
        push_eot();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (tok_expected.size() != 0) begin
            report_mismatch("records never delivered", 32'(tok_expected.size()), 32'd0);
        end
        $display("tb: %0d text items (%0d end-of-text) sent, %0d token records checked",
                 items_sent, eot_sent, records_seen);
        $display("tb: three pacing phases, %0d mismatches", err_count);
        if (err_count == 0) begin
            $display("tb_lua_token_scanner_core: done, clean");
        end else begin
            $display("tb_lua_token_scanner_core: done, errors");
        end
        $finish;
    end

endmodule
